/* rtl/tce_pkg.sv */
package tce_pkg;

  localparam int COL_W      = 7;
  localparam int ROW_W      = 6;
  localparam int CELL_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_FF  = 8'h0C;
  localparam logic [7:0] CH_CR  = 8'h0D;

  localparam logic [3:0]        RESET_FG    = 4'd7;
  localparam logic [3:0]        RESET_BG    = 4'd0;
  localparam logic [6:0]        RESET_LM    = 7'd0;
  localparam logic [6:0]        RESET_RM    = 7'd80;
  localparam logic [CELL_W-1:0] RESET_BLANK = {RESET_BG, RESET_FG, 8'h00};

  typedef enum logic [2:0] {
    OP_PUT    = 3'd0,
    OP_CLEAR  = 3'd1,
    OP_MOVE   = 3'd2,
    OP_SCROLL = 3'd3,
    OP_READ   = 3'd4
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FG = 2'd0,
    REG_BG = 2'd1,
    REG_LM = 2'd2,
    REG_RM = 2'd3
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SWEEP,
    ST_DRAIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]  operation;
    logic [7:0]  char_code;
    logic [6:0]  target_col;
    logic [4:0]  target_row;
    logic [4:0]  scroll_count;
    logic        update_cursor;
  } in_item_t;

  typedef struct packed {
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [10:0] cursor_position;
    logic        cursor_publish;
    logic [7:0]  read_char;
    logic [7:0]  read_attr;
  } out_item_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             wr_en;
    logic             scroll;
    logic [1:0]       scroll_n;
  } put_res_t;

endpackage

/* rtl/tce_stream_if.sv */
interface tce_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/text_console_character_engine.sv */
// channel   | direction | payload     | transaction when
// ----------+-----------+-------------+------------------------------
// in_i      | sink      | in_item_t   | in_i.valid && in_i.ready
// out_o     | source    | out_item_t  | out_o.valid && out_o.ready
// cfg       | write     | 7-bit data  | cfg_we_i high at clock edge
//
// put char, move cursor, read cell and unused codes go from idle straight to done.
// clear, scroll and a put char that runs off the last row go through the
// setup, sweep, drain and done states: the cell store is swept one cell a
// cycle through its single read port.
// after reset a clearing pass fills the store with blanks before in_i.ready
// rises; config writes are taken.
// a result waiting on out_o does not block the next input transaction.
module text_console_character_engine #(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS    = 25,
  parameter int TAB_STOP       = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  tce_stream_if.sink                    in_i,
  tce_stream_if.source                  out_o,
  input  logic                          cfg_we_i,
  input  logic [tce_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tce_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import tce_pkg::*;

  localparam int CELLS = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(CELLS + 1);

  // configuration registers
  logic [3:0] fg_q, bg_q;
  logic [6:0] lm_q, rm_q;
  logic [7:0] attr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q <= RESET_FG;
      bg_q <= RESET_BG;
      lm_q <= RESET_LM;
      rm_q <= RESET_RM;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_index_i))
        REG_FG:  fg_q <= cfg_data_i[3:0];
        REG_BG:  bg_q <= cfg_data_i[3:0];
        REG_LM:  lm_q <= cfg_data_i;
        REG_RM:  rm_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign attr = {bg_q, fg_q};

  // control and cursor state
  state_e            state_q, state_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  op_e               op_q, op_d;
  logic              upd_q, upd_d;
  logic              blank_all_q, blank_all_d;
  logic [4:0]        n_q, n_d;
  logic [CELL_W-1:0] blank_q, blank_d;
  logic [CW-1:0]     limit_q, limit_d;
  logic [AW-1:0]     offset_q, offset_d;
  logic [AW-1:0]     addr_q, addr_d;
  logic              wpend_q, wpend_d;
  logic [AW-1:0]     waddr_q, waddr_d;
  logic              wcopy_q, wcopy_d;
  logic              init_q, init_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  // memory port signals
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [CELL_W-1:0] mem_rdata;

  // input decode
  in_item_t          item;
  op_e               in_op;
  logic              in_fire;
  logic              out_free;
  logic [COL_W-1:0]  tc_sat;
  logic [ROW_W-1:0]  tr_sat;
  logic [AW-1:0]     cur_addr;
  logic [AW-1:0]     tgt_addr;
  logic              sweep_copy;
  logic              sweep_last;
  put_res_t          put_res;

  assign item      = in_i.payload;
  assign in_op     = op_e'(item.operation);
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire   = in_i.valid && in_i.ready;
  assign out_free  = !out_valid_q || out_o.ready;

  // targets saturate to the last column and row
  assign tc_sat = (item.target_col > COL_W'(SCREEN_COLUMNS - 1))
                ? COL_W'(SCREEN_COLUMNS - 1) : item.target_col;
  assign tr_sat = (ROW_W'(item.target_row) > ROW_W'(SCREEN_ROWS - 1))
                ? ROW_W'(SCREEN_ROWS - 1) : ROW_W'(item.target_row);

  assign cur_addr = AW'(row_q * SCREEN_COLUMNS + col_q);
  assign tgt_addr = AW'(tr_sat * SCREEN_COLUMNS + tc_sat);

  // sweep: cells below the copy limit take the cell offset rows further down
  assign sweep_copy = (CW'(addr_q) < limit_q);
  assign sweep_last = (addr_q == AW'(CELLS - 1));

  tce_cursor_step #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS),
    .TAB_STOP       (TAB_STOP)
  ) u_step (
    .ch_i           (item.char_code),
    .col_i          (col_q),
    .row_i          (row_q),
    .left_margin_i  (lm_q),
    .right_margin_i (rm_q),
    .res_o          (put_res)
  );

  tce_cell_mem #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_op)
            OP_CLEAR, OP_SCROLL: state_d = ST_SETUP;
            OP_PUT:              state_d = put_res.scroll ? ST_SETUP : ST_DONE;
            default:             state_d = ST_DONE;
          endcase
        end
      end
      ST_SETUP: state_d = ST_SWEEP;
      ST_SWEEP: begin
        if (sweep_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = init_q ? ST_IDLE : ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    col_d       = col_q;
    row_d       = row_q;
    op_d        = op_q;
    upd_d       = upd_q;
    blank_all_d = blank_all_q;
    n_d         = n_q;
    blank_d     = blank_q;
    limit_d     = limit_q;
    offset_d    = offset_q;
    addr_d      = addr_q;
    wpend_d     = 1'b0;
    waddr_d     = waddr_q;
    wcopy_d     = wcopy_q;
    init_d      = init_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_d       = out_q;

    mem_we    = wpend_q;
    mem_waddr = waddr_q;
    mem_wdata = wcopy_q ? mem_rdata : blank_q;
    mem_re    = 1'b0;
    mem_raddr = AW'(addr_q + offset_q);

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          op_d  = in_op;
          upd_d = item.update_cursor;
          case (in_op)
            OP_PUT: begin
              col_d       = put_res.col;
              row_d       = put_res.row;
              mem_we      = put_res.wr_en;
              mem_waddr   = cur_addr;
              mem_wdata   = {attr, item.char_code};
              n_d         = 5'(put_res.scroll_n);
              blank_all_d = 1'b0;
              blank_d     = {attr, 8'h00};
            end
            OP_CLEAR: begin
              col_d       = '0;
              row_d       = '0;
              blank_all_d = 1'b1;
              blank_d     = {attr, 8'h00};
            end
            OP_MOVE: begin
              col_d = tc_sat;
              row_d = tr_sat;
            end
            OP_SCROLL: begin
              n_d         = item.scroll_count;
              blank_all_d = 1'b0;
              blank_d     = {attr, 8'h00};
              row_d       = (row_q > ROW_W'(item.scroll_count))
                          ? row_q - ROW_W'(item.scroll_count) : '0;
            end
            OP_READ: begin
              mem_re    = 1'b1;
              mem_raddr = tgt_addr;
            end
            default: ;
          endcase
        end
      end
      ST_SETUP: begin
        addr_d   = '0;
        offset_d = AW'(n_q * SCREEN_COLUMNS);
        if (blank_all_q || (n_q >= SCREEN_ROWS)) begin
          limit_d = '0;
        end else begin
          limit_d = CW'((SCREEN_ROWS - n_q) * SCREEN_COLUMNS);
        end
      end
      ST_SWEEP: begin
        // read the source now, write the destination next cycle
        mem_re  = sweep_copy;
        wpend_d = 1'b1;
        waddr_d = addr_q;
        wcopy_d = sweep_copy;
        addr_d  = AW'(addr_q + 1'b1);
      end
      ST_DRAIN: begin
        init_d = 1'b0;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d           = 1'b1;
          out_d.cursor_col      = col_q;
          out_d.cursor_row      = 5'(row_q);
          out_d.cursor_position = 11'(row_q * SCREEN_COLUMNS + col_q);
          out_d.cursor_publish  = 1'b0;
          out_d.read_char       = '0;
          out_d.read_attr       = '0;
          case (op_q)
            OP_PUT, OP_CLEAR, OP_MOVE, OP_SCROLL: begin
              out_d.cursor_publish = upd_q;
            end
            OP_READ: begin
              out_d.read_char = mem_rdata[7:0];
              out_d.read_attr = mem_rdata[15:8];
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  // control registers; reset starts the clearing pass with the reset colour
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SETUP;
      col_q       <= '0;
      row_q       <= '0;
      op_q        <= OP_PUT;
      upd_q       <= 1'b0;
      blank_all_q <= 1'b1;
      n_q         <= '0;
      blank_q     <= RESET_BLANK;
      addr_q      <= '0;
      wpend_q     <= 1'b0;
      init_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      op_q        <= op_d;
      upd_q       <= upd_d;
      blank_all_q <= blank_all_d;
      n_q         <= n_d;
      blank_q     <= blank_d;
      addr_q      <= addr_d;
      wpend_q     <= wpend_d;
      init_q      <= init_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    limit_q  <= limit_d;
    offset_q <= offset_d;
    waddr_q  <= waddr_d;
    wcopy_q  <= wcopy_d;
    out_q    <= out_d;
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

endmodule

/* rtl/tce_cell_mem.sv */
module tce_cell_mem #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [tce_pkg::CELL_W-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [AW-1:0]             raddr_i,
  output logic [tce_pkg::CELL_W-1:0] rdata_o
);
  import tce_pkg::*;

  logic [CELL_W-1:0] mem [DEPTH];
  logic [CELL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/tce_cursor_step.sv */
module tce_cursor_step #(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS    = 25,
  parameter int TAB_STOP       = 4
) (
  input  logic [7:0]                ch_i,
  input  logic [tce_pkg::COL_W-1:0] col_i,
  input  logic [tce_pkg::ROW_W-1:0] row_i,
  input  logic [6:0]                left_margin_i,
  input  logic [6:0]                right_margin_i,
  output tce_pkg::put_res_t         res_o
);
  import tce_pkg::*;

  localparam int TAB_ENTRIES = 2 ** COL_W;

  // next tab stop for every column, built at elaboration
  function automatic logic [TAB_ENTRIES*8-1:0] tab_table();
    logic [TAB_ENTRIES*8-1:0] t;
    t = '0;
    for (int i = 0; i < TAB_ENTRIES; i++) begin
      t[i*8 +: 8] = 8'(((i / TAB_STOP) + 1) * TAB_STOP);
    end
    return t;
  endfunction

  localparam logic [TAB_ENTRIES*8-1:0] TAB_NEXT = tab_table();

  logic [7:0]       rm;
  logic [7:0]       lm;
  logic [7:0]       c0;
  logic [7:0]       c1;
  logic [7:0]       c2;
  logic [ROW_W:0]   r0;
  logic [ROW_W:0]   r1;
  logic [ROW_W:0]   r2;
  logic             wr;

  // effective margins
  always_comb begin
    if (right_margin_i == '0) begin
      rm = 8'd1;
    end else if ({1'b0, right_margin_i} > 8'(SCREEN_COLUMNS)) begin
      rm = 8'(SCREEN_COLUMNS);
    end else begin
      rm = {1'b0, right_margin_i};
    end
    if ({1'b0, left_margin_i} > rm - 8'd1) begin
      lm = rm - 8'd1;
    end else begin
      lm = {1'b0, left_margin_i};
    end
  end

  always_comb begin
    c0 = {1'b0, col_i};
    r0 = {1'b0, row_i};
    c1 = c0;
    r1 = r0;
    wr = 1'b0;
    case (ch_i)
      CH_LF: begin
        c1 = lm;
        r1 = r0 + 1'b1;
      end
      CH_CR: begin
        c1 = lm;
      end
      CH_FF: begin
        r1 = r0 + 1'b1;
      end
      CH_TAB: begin
        c1 = TAB_NEXT[col_i*8 +: 8];
      end
      CH_BS: begin
        if (c0 <= lm) begin
          if (row_i != '0) begin
            c1 = rm - 8'd1;
            r1 = r0 - 1'b1;
          end
        end else begin
          c1 = c0 - 8'd1;
        end
      end
      default: begin
        wr = (c0 < 8'(SCREEN_COLUMNS));
        c1 = c0 + 8'd1;
      end
    endcase

    // wrap at the right margin
    c2 = c1;
    r2 = r1;
    if (c1 >= rm) begin
      c2 = c1 - (rm - lm);
      if (c2 >= rm) begin
        c2 = lm;
      end
      r2 = r1 + 1'b1;
    end

    res_o.col      = c2[COL_W-1:0];
    res_o.wr_en    = wr;
    res_o.scroll   = 1'b0;
    res_o.scroll_n = '0;
    res_o.row      = r2[ROW_W-1:0];
    // past the last row: scroll just enough to land on it
    if (r2 >= (ROW_W+1)'(SCREEN_ROWS)) begin
      res_o.scroll   = 1'b1;
      res_o.scroll_n = 2'(r2 - (ROW_W+1)'(SCREEN_ROWS - 1));
      res_o.row      = ROW_W'(SCREEN_ROWS - 1);
    end
  end

endmodule
